FILE: rtl/led_matrix_row_scan_shifter_top_macros.svh
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter assertion macros
// Concurrent check macros used by the top-level RTL file of the block.
// -----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCAN_SHIFTER_TOP_MACROS_SVH
`define LED_MATRIX_ROW_SCAN_SHIFTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// check outside reset
`define LMRSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also covers reset cycles
`define LMRSS_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMRSS_ASSERT(lbl, clk, rst, prop, msg)
`define LMRSS_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/lmrss_pkg.sv
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter package
// Command codes, fixed field widths and shared types of the scan engine.
// -----------------------------------------------------------------------------
package lmrss_pkg;

   localparam int PIXEL_ADDR_WIDTH = 10;
   localparam int ROW_CODE_WIDTH   = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct packed {
      logic [ROW_CODE_WIDTH-1:0] row_code;
      logic                      latch_after;
   } scan_info_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } store_state_type;

endpackage

FILE: rtl/lmrss_if.sv
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter channels
// Valid/ready channels for command transactions and scan results.
// -----------------------------------------------------------------------------
interface lmrss_req_if;
   import lmrss_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [PIXEL_ADDR_WIDTH-1:0] pixel_addr;
   logic                        pixel_on;

   modport source (output valid, output cmd, output pixel_addr, output pixel_on,
                   input ready);
   modport sink (input valid, input cmd, input pixel_addr, input pixel_on,
                 output ready);
endinterface

interface lmrss_rsp_if;
   import lmrss_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      serial_bit;
   logic [ROW_CODE_WIDTH-1:0] row_code;
   logic                      latch_after;

   modport source (output valid, output serial_bit, output row_code,
                   output latch_after, input ready);
   modport sink (input valid, input serial_bit, input row_code, input latch_after,
                 output ready);
endinterface

FILE: rtl/lmrss_frame_store.sv
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter frame store
// One-bit-per-pixel memory with registered read and a clearing sweep after reset.
// -----------------------------------------------------------------------------
module lmrss_frame_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data,
   output logic              store_ready
);
   import lmrss_pkg::*;

   logic              mem [DEPTH];
   store_state_type   state_ff;
   store_state_type   state_in;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [ADDR_W-1:0] clear_addr_in;
   logic              clearing;
   logic              clear_last;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_wdata;
   logic              rd_data_ff;

   assign clear_last = (clear_addr_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing    = 1'b0;
      store_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   store_ready = 1'b1;
         default:  clearing = 1'b1;
      endcase
   end

   assign clear_addr_in = clearing ? clear_addr_ff + 1'b1 : '0;

   // sweep zeros through the store, then take port writes
   assign mem_we    = clearing | wr_en;
   assign mem_waddr = clearing ? clear_addr_ff : wr_addr;
   assign mem_wdata = clearing ? 1'b0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lmrss_scan_counter.sv
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter scan counter
// Pixel, segment and row-group counters with frame store address generation.
// -----------------------------------------------------------------------------
module lmrss_scan_counter #(
   parameter int SEGMENT_WIDTH = 32,
   parameter int ROW_GROUPS    = 8,
   parameter int SEGMENTS      = 4,
   parameter int ADDR_W        = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   output logic [ADDR_W-1:0]       rd_addr,
   output lmrss_pkg::scan_info_type info
);
   import lmrss_pkg::*;

   localparam int PIX_W  = (SEGMENT_WIDTH > 1) ? $clog2(SEGMENT_WIDTH) : 1;
   localparam int SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int GRP_W  = (ROW_GROUPS > 1) ? $clog2(ROW_GROUPS) : 1;
   localparam int STRIDE = SEGMENT_WIDTH * ROW_GROUPS;

   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] pix_in;
   logic [SEG_W-1:0] seg_ff;
   logic [SEG_W-1:0] seg_in;
   logic [GRP_W-1:0] group_ff;
   logic [GRP_W-1:0] group_in;
   logic [PIX_W-1:0] pix_rev;
   logic [SEG_W-1:0] seg_rev;
   logic [GRP_W-1:0] code;
   logic             pix_last;
   logic             seg_last;
   logic             group_last;

   assign pix_last   = (pix_ff == PIX_W'(SEGMENT_WIDTH - 1));
   assign seg_last   = (seg_ff == SEG_W'(SEGMENTS - 1));
   assign group_last = (group_ff == GRP_W'(ROW_GROUPS - 1));

   // segments run from the highest offset down, pixels from the top of the segment
   assign pix_rev = PIX_W'(SEGMENT_WIDTH - 1) - pix_ff;
   assign seg_rev = SEG_W'(SEGMENTS - 1) - seg_ff;

   assign rd_addr = ADDR_W'(seg_rev) * ADDR_W'(STRIDE)
                  + ADDR_W'(group_ff) * ADDR_W'(SEGMENT_WIDTH)
                  + ADDR_W'(pix_rev);

   assign code = (group_ff == '0) ? GRP_W'(ROW_GROUPS - 1) : group_ff - 1'b1;

   assign info.row_code    = ROW_CODE_WIDTH'(code);
   assign info.latch_after = pix_last & seg_last;

   always_comb begin
      pix_in   = pix_ff;
      seg_in   = seg_ff;
      group_in = group_ff;
      if (advance) begin
         pix_in = pix_last ? '0 : pix_ff + 1'b1;
         if (pix_last) begin
            seg_in = seg_last ? '0 : seg_ff + 1'b1;
            if (seg_last) begin
               group_in = group_last ? '0 : group_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff   <= '0;
         seg_ff   <= '0;
         group_ff <= '0;
      end else begin
         pix_ff   <= pix_in;
         seg_ff   <= seg_in;
         group_ff <= group_in;
      end
   end

endmodule

FILE: rtl/led_matrix_row_scan_shifter_top.sv
// -----------------------------------------------------------------------------
// LED matrix row-scan shifter top level
// A tick transaction's result passes the frame store read register, then
// the output register, which holds it while rsp ready is low.
// Throughput: one transaction per cycle while the result side keeps up;
// writes give no result.
// Reset: counters clear at once; the frame store sweeps zeros through all
// SEGMENTS*SEGMENT_WIDTH*ROW_GROUPS locations (1024 by default) with req ready low.
// -----------------------------------------------------------------------------
`include "led_matrix_row_scan_shifter_top_macros.svh"

module led_matrix_row_scan_shifter_top #(
   parameter int SEGMENT_WIDTH = 32,
   parameter int ROW_GROUPS    = 8,
   parameter int SEGMENTS      = 4
) (
   input logic         clock,
   input logic         reset,
   lmrss_req_if.sink   req_ch,
   lmrss_rsp_if.source rsp_ch
);
   import lmrss_pkg::*;

   localparam int FRAME_PIXELS = SEGMENTS * SEGMENT_WIDTH * ROW_GROUPS;
   localparam int ADDR_W       = $clog2(FRAME_PIXELS);
   localparam int CMP_W        = ((ADDR_W > PIXEL_ADDR_WIDTH) ? ADDR_W : PIXEL_ADDR_WIDTH) + 1;

   logic                      store_ready;
   logic                      store_rd_data;
   logic [ADDR_W-1:0]         scan_addr;
   scan_info_type             scan_info;
   logic                      req_fire;
   logic                      tick_accept;
   logic                      write_accept;
   logic                      addr_in_range;
   logic                      out_free;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   scan_info_type             s1_info_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      serial_bit_ff;
   logic [ROW_CODE_WIDTH-1:0] row_code_ff;
   logic                      latch_after_ff;

   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = store_ready & (~s1_valid_ff | out_free);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign tick_accept  = req_fire & (req_ch.cmd == CMD_TICK);
   assign write_accept = req_fire & (req_ch.cmd == CMD_WRITE);

   // drop writes beyond the store
   assign addr_in_range = CMP_W'(req_ch.pixel_addr) < CMP_W'(FRAME_PIXELS);

   lmrss_frame_store #(
      .DEPTH  (FRAME_PIXELS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (write_accept & addr_in_range),
      .wr_addr     (ADDR_W'(req_ch.pixel_addr)),
      .wr_data     (req_ch.pixel_on),
      .rd_en       (tick_accept),
      .rd_addr     (scan_addr),
      .rd_data     (store_rd_data),
      .store_ready (store_ready)
   );

   lmrss_scan_counter #(
      .SEGMENT_WIDTH (SEGMENT_WIDTH),
      .ROW_GROUPS    (ROW_GROUPS),
      .SEGMENTS      (SEGMENTS),
      .ADDR_W        (ADDR_W)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (tick_accept),
      .rd_addr (scan_addr),
      .info    (scan_info)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_valid_ff && out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_info_ff <= scan_info;
      end
   end

   // advance the read stage into the output register
   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         serial_bit_ff  <= store_rd_data;
         row_code_ff    <= s1_info_ff.row_code;
         latch_after_ff <= s1_info_ff.latch_after;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.serial_bit  = serial_bit_ff;
   assign rsp_ch.row_code    = row_code_ff;
   assign rsp_ch.latch_after = latch_after_ff;

   `LMRSS_ASSERT(a_tick_enters_read_stage, clock, reset, tick_accept |=> s1_valid_ff, "tick transaction did not enter the read stage")
   `LMRSS_ASSERT(a_read_data_held, clock, reset, (s1_valid_ff && !out_free) |=> (store_rd_data == $past(store_rd_data)), "read data changed while the read stage was stalled")
   `LMRSS_ASSERT(a_no_accept_while_clearing, clock, reset, !store_ready |-> !req_fire, "transaction accepted during the store clear")
   `LMRSS_ASSERT_RST(a_reset_empties_pipe, clock, reset |=> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule
